/* sv/cht_pkg.sv */
// Shared types, codes and defaults of the chained hash table.
package cht_pkg;

  localparam int BUCKETS_DEF    = 16;
  localparam int ENTRIES_DEF    = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_PUT    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_POOL_OUT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] lookup_key;
    logic [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        had_entry;
    logic [31:0] value_out;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_HASH,
    CMD_HEAD_RD,
    CMD_HEAD_TAKE,
    CMD_ENTRY_RD,
    CMD_ADVANCE,
    CMD_REPLY_MISS,
    CMD_REPLY_FULL,
    CMD_REPLY_HIT,
    CMD_PUT_UPDATE,
    CMD_FREE_RD,
    CMD_PUT_INSERT,
    CMD_RM_UNLINK,
    CMD_RM_FREE
  } cmd_t;

  typedef struct packed {
    logic       hash_skip;
    logic       hash_done;
    logic       clear_done;
    logic       cur_nil;
    logic       key_match;
    logic       free_nil;
    logic [1:0] action;
  } stat_t;

endpackage

/* sv/cht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/cht_dp.sv */
// Datapath: table memories, chain walk registers, hashing and the result word.
module cht_dp #(
  parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
  parameter int ENTRIES    = cht_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cht_pkg::cmd_t cmd,
  input  cht_pkg::req_t req,
  output cht_pkg::stat_t stat,
  output cht_pkg::rsp_t rsp,
  output logic          done
);

  localparam int KEFF = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VEFF = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int BW   = $clog2(BUCKETS);
  localparam int AW   = $clog2(ENTRIES);
  localparam int LW   = $clog2(ENTRIES + 1);
  localparam int HW   = $clog2(KEFF);
  localparam int CLR  = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int CW   = $clog2(CLR);
  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [LW-1:0] NIL    = LW'(ENTRIES);
  localparam logic [BW:0]   BK     = (BW + 1)'(BUCKETS);
  localparam logic [CW:0]   CLR_B  = (CW + 1)'(BUCKETS);
  localparam logic [CW:0]   CLR_E  = (CW + 1)'(ENTRIES);
  localparam logic [CW-1:0] CLR_END = CW'(CLR - 1);

  logic [KEFF-1:0] key;
  logic [VEFF-1:0] val;
  logic [1:0]      action;
  logic [BW-1:0]   rem;
  logic [HW-1:0]   hcnt;
  logic [LW-1:0]   cur;
  logic [LW-1:0]   prev;
  logic [LW-1:0]   free_head;
  logic [LW-1:0]   count;
  logic [CW-1:0]   clr;

  logic [BW:0]     rem_sh;
  logic [BW-1:0]   rem_next;
  logic [BW-1:0]   bucket;

  logic            head_we, head_re, key_we, val_we, link_we, ent_re, link_re;
  logic [BW-1:0]   head_waddr;
  logic [LW-1:0]   head_wdata, head_rdata;
  logic [AW-1:0]   ent_waddr, link_waddr, link_raddr;
  logic [LW-1:0]   link_wdata, link_rdata;
  logic [KEFF-1:0] key_rdata;
  logic [VEFF-1:0] val_rdata;

  assign rem_sh   = {rem, key[hcnt]};
  assign rem_next = (rem_sh >= BK) ? BW'(rem_sh - BK) : BW'(rem_sh);
  assign bucket   = POW2 ? BW'(key) : rem;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = cur;
    head_re    = (cmd == cht_pkg::CMD_HEAD_RD);
    ent_re     = (cmd == cht_pkg::CMD_ENTRY_RD);
    link_re    = ent_re || (cmd == cht_pkg::CMD_FREE_RD);
    link_raddr = (cmd == cht_pkg::CMD_FREE_RD) ? free_head[AW-1:0] : cur[AW-1:0];
    key_we     = 1'b0;
    val_we     = 1'b0;
    ent_waddr  = cur[AW-1:0];
    link_we    = 1'b0;
    link_waddr = cur[AW-1:0];
    link_wdata = free_head;
    case (cmd)
      cht_pkg::CMD_CLEAR: begin
        head_we    = ({1'b0, clr} < CLR_B);
        head_waddr = BW'(clr);
        head_wdata = NIL;
        link_we    = ({1'b0, clr} < CLR_E);
        link_waddr = AW'(clr);
        link_wdata = LW'(clr) + LW'(1);
      end
      cht_pkg::CMD_PUT_UPDATE: begin
        val_we = 1'b1;
      end
      cht_pkg::CMD_PUT_INSERT: begin
        // The free entry becomes the new head of the bucket chain.
        ent_waddr  = free_head[AW-1:0];
        key_we     = 1'b1;
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_waddr = free_head[AW-1:0];
        link_wdata = head_rdata;
        head_we    = 1'b1;
        head_wdata = free_head;
      end
      cht_pkg::CMD_RM_UNLINK: begin
        if (prev == NIL) begin
          head_we    = 1'b1;
          head_wdata = link_rdata;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev[AW-1:0];
          link_wdata = link_rdata;
        end
      end
      cht_pkg::CMD_RM_FREE: begin
        link_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(bucket), .rdata(head_rdata)
  );

  cht_ram #(.WIDTH(KEFF), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(key_we), .waddr(ent_waddr), .wdata(key),
    .re(ent_re), .raddr(cur[AW-1:0]), .rdata(key_rdata)
  );

  cht_ram #(.WIDTH(VEFF), .DEPTH(ENTRIES)) u_vals (
    .clk(clk), .we(val_we), .waddr(ent_waddr), .wdata(val),
    .re(ent_re), .raddr(cur[AW-1:0]), .rdata(val_rdata)
  );

  cht_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      free_head <= '0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd)
        cht_pkg::CMD_CLEAR: begin
          clr <= clr + CW'(1);
        end
        cht_pkg::CMD_LOAD: begin
          key    <= req.lookup_key[KEFF-1:0];
          val    <= req.new_value[VEFF-1:0];
          action <= req.action;
          rem    <= '0;
          hcnt   <= HW'(KEFF - 1);
        end
        cht_pkg::CMD_HASH: begin
          rem  <= rem_next;
          hcnt <= hcnt - HW'(1);
        end
        cht_pkg::CMD_HEAD_TAKE: begin
          cur  <= head_rdata;
          prev <= NIL;
        end
        cht_pkg::CMD_ADVANCE: begin
          prev <= cur;
          cur  <= link_rdata;
        end
        cht_pkg::CMD_REPLY_MISS: begin
          done <= 1'b1;
          rsp  <= '{status: cht_pkg::ST_MISSING, had_entry: 1'b0, value_out: '0,
                    entry_count: 7'(count)};
        end
        cht_pkg::CMD_REPLY_FULL: begin
          done <= 1'b1;
          rsp  <= '{status: cht_pkg::ST_POOL_OUT, had_entry: 1'b0, value_out: '0,
                    entry_count: 7'(count)};
        end
        cht_pkg::CMD_REPLY_HIT, cht_pkg::CMD_PUT_UPDATE: begin
          done <= 1'b1;
          rsp  <= '{status: cht_pkg::ST_OK, had_entry: 1'b1, value_out: 32'(val_rdata),
                    entry_count: 7'(count)};
        end
        cht_pkg::CMD_PUT_INSERT: begin
          free_head <= link_rdata;
          count     <= count + LW'(1);
          done      <= 1'b1;
          rsp       <= '{status: cht_pkg::ST_OK, had_entry: 1'b0, value_out: '0,
                         entry_count: 7'(count + LW'(1))};
        end
        cht_pkg::CMD_RM_FREE: begin
          free_head <= cur;
          count     <= count - LW'(1);
          done      <= 1'b1;
          rsp       <= '{status: cht_pkg::ST_OK, had_entry: 1'b1,
                         value_out: 32'(val_rdata), entry_count: 7'(count - LW'(1))};
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.hash_skip  = POW2;
  assign stat.hash_done  = (hcnt == '0);
  assign stat.clear_done = (clr == CLR_END);
  assign stat.cur_nil    = (cur == NIL);
  assign stat.key_match  = (key_rdata == key);
  assign stat.free_nil   = (free_head == NIL);
  assign stat.action     = action;

endmodule

/* sv/cht_ctrl.sv */
// Controller: sequences clearing, hashing, the chain walk and each operation.
module cht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cht_pkg::stat_t stat,
  output cht_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD_TAKE, S_WALK, S_COMPARE,
    S_INSERT, S_UNLINK, S_FREE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = cht_pkg::CMD_NONE;
    case (state)
      S_CLEAR: begin
        cmd = cht_pkg::CMD_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd        = cht_pkg::CMD_LOAD;
          state_next = stat.hash_skip ? S_HEAD_RD : S_HASH;
        end
      end
      S_HASH: begin
        cmd = cht_pkg::CMD_HASH;
        if (stat.hash_done) state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd        = cht_pkg::CMD_HEAD_RD;
        state_next = S_HEAD_TAKE;
      end
      S_HEAD_TAKE: begin
        cmd        = cht_pkg::CMD_HEAD_TAKE;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!stat.cur_nil) begin
          cmd        = cht_pkg::CMD_ENTRY_RD;
          state_next = S_COMPARE;
        end else if (stat.action != cht_pkg::ACT_PUT) begin
          cmd        = cht_pkg::CMD_REPLY_MISS;
          state_next = S_IDLE;
        end else if (stat.free_nil) begin
          cmd        = cht_pkg::CMD_REPLY_FULL;
          state_next = S_IDLE;
        end else begin
          cmd        = cht_pkg::CMD_FREE_RD;
          state_next = S_INSERT;
        end
      end
      S_COMPARE: begin
        if (!stat.key_match) begin
          cmd        = cht_pkg::CMD_ADVANCE;
          state_next = S_WALK;
        end else if (stat.action == cht_pkg::ACT_PUT) begin
          cmd        = cht_pkg::CMD_PUT_UPDATE;
          state_next = S_IDLE;
        end else if (stat.action == cht_pkg::ACT_REMOVE) begin
          state_next = S_UNLINK;
        end else begin
          cmd        = cht_pkg::CMD_REPLY_HIT;
          state_next = S_IDLE;
        end
      end
      S_INSERT: begin
        cmd        = cht_pkg::CMD_PUT_INSERT;
        state_next = S_IDLE;
      end
      S_UNLINK: begin
        cmd        = cht_pkg::CMD_RM_UNLINK;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd        = cht_pkg::CMD_RM_FREE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

/* sv/chained_hash_table.sv */
// After a word is accepted, the key is hashed to a bucket, the bucket head is read, and each
// chain link in turn is read and compared to the key; done rises with the result.
// A bucket count that is not a power of two takes the key modulo BUCKETS over min(KEY_BITS, 32) bits.
// The block takes one word at a time; busy falls as done rises.
// Reset: a clearing pass empties the buckets and builds the free list.
// The result is on rsp for the single cycle that done is high; the receiver cannot stall.
module chained_hash_table #(
  parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
  parameter int ENTRIES    = cht_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = cht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cht_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output cht_pkg::rsp_t rsp
);

  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t stat;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  cht_dp #(
    .BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(req), .stat(stat), .rsp(rsp), .done(done)
  );

  // A result word only follows an operation in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without operation");

  // An accepted word keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not start");

  // Coming out of reset, the clearing pass holds off new words.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy) else $error("accepting during clear");

  // A miss or pool-out reply never claims the key was present and returns a zero value.
  a_miss_flag: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != cht_pkg::ST_OK) |-> (!rsp.had_entry && rsp.value_out == '0))
    else $error("inconsistent miss reply");

endmodule
